### rtl/core/vde_pkg.sv
// Shared types and constants for the vector distance engine.
// No dependencies; imported by vde_accum, vde_finish and the top level (not by vde_checker).
package vde_pkg;

  // Metric selection codes as written to the metric_mode register.
  typedef enum logic [1:0] {
    MODE_EUCLID    = 2'd0,
    MODE_MANHATTAN = 2'd1,
    MODE_COSINE    = 2'd2,
    MODE_HAMMING   = 2'd3
  } mode_t;

  // Register index decoded from the configuration address.
  localparam logic REG_METRIC_MODE = 1'b0;

  localparam int VAL_W   = 16;  // Q8.8 element
  localparam int OPD_W   = 17;  // multiplier operand, holds a difference
  localparam int PROD_W  = 34;  // 17 x 17 signed product
  localparam int SQ_W    = 45;
  localparam int ABS_W   = 27;
  localparam int DOT_W   = 42;
  localparam int NORM_W  = 41;
  localparam int MIS_W   = 11;
  localparam int DIST_W  = 32;

  localparam int ADD_W   = 84;  // shared adder of the finishing unit
  localparam int NPROD_W = 82;  // product of the two squared norms
  localparam int QUO_W   = 33;  // quotient of the cosine ratio
  localparam int SQRT_W  = 45;  // radicand
  localparam int SRES_W  = 46;  // root accumulator
  localparam int STEP_W  = 6;

  localparam logic [STEP_W-1:0] MUL_LAST = 6'd41;  // 42 shift-add passes
  localparam logic [STEP_W-1:0] DIV_LAST = 6'd32;  // 33 quotient bits
  localparam logic [SQRT_W-1:0] SQRT_TOP = {1'b1, {(SQRT_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] ONE_Q16  = 32'd65536;

  // Accumulator snapshot handed to the finishing unit on the last element.
  typedef struct packed {
    mode_t              mode;
    logic [SQ_W-1:0]    sq;
    logic [ABS_W-1:0]   abs_sum;
    logic [DOT_W-1:0]   dot;     // two's complement
    logic [NORM_W-1:0]  qn;
    logic [NORM_W-1:0]  rn;
    logic [MIS_W-1:0]   mis;
  } vde_snap_t;

endpackage

### rtl/core/vde_accum.sv
// Element accumulator: one shared 17x17 signed multiplier stepped over four passes.
// Depends on vde_pkg; hands an accumulator snapshot to vde_finish.
module vde_accum import vde_pkg::*; #(
  parameter int DIM = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic signed [VAL_W-1:0] x_value,
  input  logic signed [VAL_W-1:0] ref_value,
  input  logic                    last,
  input  mode_t                   mode,
  output logic                    busy,
  output logic                    start,
  output vde_snap_t               snap
);

  localparam int CNT_W = $clog2(DIM + 1);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_HAND} astate_t;

  astate_t                   state;
  logic [1:0]                step;
  logic signed [VAL_W-1:0]   xr;
  logic signed [VAL_W-1:0]   rr;
  logic                      last_r;

  logic [SQ_W-1:0]           sq;
  logic [ABS_W-1:0]          abs_sum;
  logic [DOT_W-1:0]          dot;
  logic [NORM_W-1:0]         qn;
  logic [NORM_W-1:0]         rn;
  logic [MIS_W-1:0]          mis;
  logic [CNT_W-1:0]          cnt;

  logic signed [OPD_W-1:0]   diff;
  logic [OPD_W-1:0]          abs_diff;
  logic signed [OPD_W-1:0]   opa;
  logic signed [OPD_W-1:0]   opb;
  logic signed [PROD_W-1:0]  prod;
  logic [7:0]                x_int;
  logic [7:0]                r_int;

  assign diff     = OPD_W'(xr) - OPD_W'(rr);
  assign abs_diff = diff[OPD_W-1] ? (OPD_W'(0) - diff) : diff;

  // integer parts truncated toward zero
  assign x_int = xr[15:8] + {7'b0, (xr[15] && (xr[7:0] != 8'd0))};
  assign r_int = rr[15:8] + {7'b0, (rr[15] && (rr[7:0] != 8'd0))};

  always_comb begin
    unique case (step)
      2'd0: begin opa = diff;        opb = diff;        end
      2'd1: begin opa = OPD_W'(xr);  opb = OPD_W'(rr);  end
      2'd2: begin opa = OPD_W'(xr);  opb = OPD_W'(xr);  end
      2'd3: begin opa = OPD_W'(rr);  opb = OPD_W'(rr);  end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign prod = opa * opb;

  assign busy  = (state != A_IDLE);
  assign start = (state == A_HAND) && last_r;
  assign snap  = '{mode: mode, sq: sq, abs_sum: abs_sum, dot: dot,
                   qn: qn, rn: rn, mis: mis};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= A_IDLE;
      step    <= '0;
      sq      <= '0;
      abs_sum <= '0;
      dot     <= '0;
      qn      <= '0;
      rn      <= '0;
      mis     <= '0;
      cnt     <= '0;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (take) begin
            xr     <= x_value;
            rr     <= ref_value;
            last_r <= last;
            step   <= '0;
            // drop elements beyond DIM, but still honour the last mark
            state  <= (cnt < CNT_W'(DIM)) ? A_MUL : A_HAND;
          end
        end
        A_MUL: begin
          step <= step + 2'd1;
          unique case (step)
            2'd0: begin
              sq      <= sq + SQ_W'(prod);
              abs_sum <= abs_sum + ABS_W'(abs_diff);
              mis     <= mis + MIS_W'(x_int != r_int);
              cnt     <= cnt + CNT_W'(1);
            end
            2'd1: dot <= dot + DOT_W'(prod);
            2'd2: qn  <= qn + NORM_W'(prod);
            2'd3: begin
              rn    <= rn + NORM_W'(prod);
              state <= last_r ? A_HAND : A_IDLE;
            end
            default: ;
          endcase
        end
        A_HAND: begin
          if (last_r) begin
            sq      <= '0;
            abs_sum <= '0;
            dot     <= '0;
            qn      <= '0;
            rn      <= '0;
            mis     <= '0;
            cnt     <= '0;
          end
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/vde_finish.sv
// Finishing unit: one shared 84-bit add/subtract stepped through shift-add
// multiply, restoring divide and bit-serial square root. Depends on vde_pkg.
module vde_finish import vde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vde_snap_t         snap,
  output logic              busy,
  output logic              res_valid,
  output logic [DIST_W-1:0] result,
  input  logic              res_take
);

  typedef enum logic [2:0] {F_IDLE, F_MUL_N, F_MUL_M, F_DIV, F_SQRT, F_DONE} fstate_t;

  fstate_t              state;
  mode_t                mode;
  logic                 neg;
  logic [DOT_W-1:0]     mag;
  logic [ADD_W-1:0]     prod;
  logic [ADD_W-1:0]     mcand;
  logic [DOT_W-1:0]     mplier;
  logic [NPROD_W-1:0]   nreg;
  logic [NPROD_W-1:0]   rem;
  logic                 dbit;
  logic [QUO_W-1:0]     quo;
  logic [SQRT_W-1:0]    sv;
  logic [SRES_W-1:0]    sres;
  logic [SQRT_W-1:0]    sbit;
  logic [STEP_W-1:0]    cnt;

  logic [ADD_W-1:0]     opa;
  logic [ADD_W-1:0]     opb;
  logic                 sub;
  logic [ADD_W:0]       sum;
  logic                 ge;
  logic [NPROD_W:0]     rem_sh;
  logic [SRES_W-1:0]    root_try;
  logic [ADD_W-1:0]     prod_upd;
  logic [QUO_W-1:0]     quo_upd;
  logic [NPROD_W-1:0]   rem_upd;
  logic [SRES_W-1:0]    sres_upd;
  logic [DOT_W-1:0]     mag_in;

  assign rem_sh   = {rem, dbit};
  // root and trial bit never overlap, so OR stands in for the add
  assign root_try = sres | SRES_W'(sbit);

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (state)
      F_MUL_N, F_MUL_M: begin
        opa = prod;
        opb = mcand;
      end
      F_DIV: begin
        opa = ADD_W'(rem_sh);
        opb = ADD_W'(nreg);
        sub = 1'b1;
      end
      F_SQRT: begin
        opa = ADD_W'(sv);
        opb = ADD_W'(root_try);
        sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, opa} + {1'b0, opb ^ {ADD_W{sub}}} + (ADD_W+1)'(sub);
  assign ge  = sum[ADD_W];

  assign prod_upd = mplier[0] ? sum[ADD_W-1:0] : prod;
  assign quo_upd  = {quo[QUO_W-2:0], ge};
  assign rem_upd  = ge ? sum[NPROD_W-1:0] : rem_sh[NPROD_W-1:0];
  assign sres_upd = ge ? ((sres >> 1) | SRES_W'(sbit)) : (sres >> 1);
  assign mag_in   = snap.dot[DOT_W-1] ? (DOT_W'(0) - snap.dot) : snap.dot;

  assign busy      = (state != F_IDLE);
  assign res_valid = (state == F_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            mode <= snap.mode;
            neg  <= snap.dot[DOT_W-1];
            mag  <= mag_in;
            unique case (snap.mode)
              MODE_EUCLID: begin
                sv    <= snap.sq;
                sres  <= '0;
                sbit  <= SQRT_TOP;
                state <= F_SQRT;
              end
              MODE_MANHATTAN: begin
                result <= DIST_W'(snap.abs_sum);
                state  <= F_DONE;
              end
              MODE_COSINE: begin
                if (snap.qn == '0 || snap.rn == '0) begin
                  result <= ONE_Q16;
                  state  <= F_DONE;
                end else begin
                  prod   <= '0;
                  mcand  <= ADD_W'(snap.qn);
                  mplier <= DOT_W'(snap.rn);
                  cnt    <= '0;
                  state  <= F_MUL_N;
                end
              end
              MODE_HAMMING: begin
                result <= DIST_W'(snap.mis);
                state  <= F_DONE;
              end
            endcase
          end
        end
        F_MUL_N: begin
          if (cnt == MUL_LAST) begin
            // norm product done; square the dot magnitude next
            nreg   <= prod_upd[NPROD_W-1:0];
            prod   <= '0;
            mcand  <= ADD_W'(mag);
            mplier <= mag;
            cnt    <= '0;
            state  <= F_MUL_M;
          end else begin
            prod   <= prod_upd;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt + STEP_W'(1);
          end
        end
        F_MUL_M: begin
          if (cnt == MUL_LAST) begin
            // dividend is dot^2 << 32; its top bits already sit below the divisor
            rem   <= prod_upd[NPROD_W:1];
            dbit  <= prod_upd[0];
            quo   <= '0;
            cnt   <= '0;
            state <= F_DIV;
          end else begin
            prod   <= prod_upd;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt + STEP_W'(1);
          end
        end
        F_DIV: begin
          rem  <= rem_upd;
          dbit <= 1'b0;
          quo  <= quo_upd;
          cnt  <= cnt + STEP_W'(1);
          if (cnt == DIV_LAST) begin
            sv    <= SQRT_W'(quo_upd);
            sres  <= '0;
            sbit  <= SQRT_TOP;
            state <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (ge) begin
            sv <= sum[SQRT_W-1:0];
          end
          sres <= sres_upd;
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            if (mode == MODE_EUCLID) begin
              result <= DIST_W'(sres_upd);
            end else if (neg) begin
              result <= ONE_Q16 + DIST_W'(sres_upd[16:0]);
            end else begin
              result <= ONE_Q16 - DIST_W'(sres_upd[16:0]);
            end
            state <= F_DONE;
          end
        end
        F_DONE: begin
          if (res_take) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/vector_distance_engine_top.sv
// Distance between a streamed query vector and reference vector, one element
// pair per beat, result after the beat marked last. Holds the metric register
// and the output register; instantiates vde_accum and vde_finish (vde_pkg).
//
// One 17x17 multiplier is used four times per element beat (squared difference,
// product, two squares); a beat beyond DIM skips it. After the last beat a
// hand-off state starts the finishing unit on its single 84-bit adder: Manhattan
// and Hamming need no steps, Euclidean 23 root steps (23 root bits), cosine
// 42 + 42 shift-add passes, 33 divide steps and 23 root steps. in_stall is high
// while either unit is busy, also while a result waits in the finishing unit;
// a distance in the output register does not hold up the next vector.
module vector_distance_engine_top import vde_pkg::*; #(
  parameter int DIM = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  // element channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] x_value,
  input  logic signed [VAL_W-1:0] ref_value,
  input  logic                    last,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIST_W-1:0]       distance,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  mode_t              metric_mode;
  logic               take;
  logic               acc_busy;
  logic               fin_busy;
  logic               start;
  vde_snap_t          snap;
  logic               res_valid;
  logic [DIST_W-1:0]  result;
  logic               load;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_METRIC_MODE) ? {30'b0, metric_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_EUCLID;
    end else if (psel && penable && pwrite && paddr[2] == REG_METRIC_MODE) begin
      metric_mode <= mode_t'(pwdata[1:0]);
    end
  end

  assign in_stall = acc_busy | fin_busy;
  assign take     = in_valid & ~in_stall;

  vde_accum #(.DIM(DIM)) u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .x_value   (x_value),
    .ref_value (ref_value),
    .last      (last),
    .mode      (metric_mode),
    .busy      (acc_busy),
    .start     (start),
    .snap      (snap)
  );

  vde_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .snap      (snap),
    .busy      (fin_busy),
    .res_valid (res_valid),
    .result    (result),
    .res_take  (load)
  );

  // load a finished result whenever the output register is empty or being drained
  assign load = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      distance  <= result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/vde_checker.sv
// Port-level checks for vector_distance_engine_top, attached by bind.
// Sees only the top level's ports; no package dependency.
module vde_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] distance
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid survived reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("element beat taken without the unit going busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

endmodule

bind vector_distance_engine_top vde_checker u_vde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .distance  (distance)
);
